// ----- rtl/mft_pkg.sv -----
`default_nettype none

package mft_pkg;

   // Width of the tick counters and configuration words
   localparam int CNT_W = 12;
   localparam logic [CNT_W-1:0] CNT_MAX = 12'hFFF;

   // Configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_RX_ACTIVE_LEVEL   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TX_ACTIVE_LEVEL   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MID_BIT_THRESHOLD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RX_TIMEOUT        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_BIT_PERIOD   = 3'd4;

   // Configuration reset values
   localparam logic             RST_RX_ACTIVE_LEVEL   = 1'b1;
   localparam logic             RST_TX_ACTIVE_LEVEL   = 1'b1;
   localparam logic [CNT_W-1:0] RST_MID_BIT_THRESHOLD = 12'd800;
   localparam logic [CNT_W-1:0] RST_RX_TIMEOUT        = 12'd1504;
   localparam logic [CNT_W-1:0] RST_HALF_BIT_PERIOD   = 12'd500;

   typedef enum logic [7:0] {
      MODE_WAIT_START = 8'b0000_0001,
      MODE_RX_FRAME   = 8'b0000_0010,
      MODE_WAIT_STOP  = 8'b0000_0100,
      MODE_RX_ERROR   = 8'b0000_1000,
      MODE_TX_START   = 8'b0001_0000,
      MODE_TX_FRAME   = 8'b0010_0000,
      MODE_TX_STOP    = 8'b0100_0000,
      MODE_TX_IDLE    = 8'b1000_0000
   } mode_type;

   // Saturating tick counter increment
   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/manchester_frame_transceiver_unit.sv -----
// An accepted item passes the input register, then the result register. One item per
// cycle without rsp_stall; all receive/transmit state updates in one pass per item.
// The input register takes a new item while a stalled result waits in the result register.
// Reset (synchronous, active high) empties both stages, returns the receiver to waiting
// for a start edge, idles the transmitter and loads the configuration defaults.
`default_nettype none

module manchester_frame_transceiver_unit #(
   parameter int FRAME_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,

   // configuration write port
   input  wire logic                           csr_we,
   input  wire logic [mft_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mft_pkg::CNT_W-1:0]      csr_wdata,

   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_action,
   input  wire logic        req_rx_level,
   input  wire logic [31:0] req_tx_frame,

   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_tx_line,
   output logic             rsp_frame_valid,
   output logic [31:0]      rsp_frame_data,
   output logic             rsp_frame_error,
   output logic             rsp_tx_busy
);

   // bit counter must hold FRAME_BITS itself
   localparam int BC_W = $clog2(FRAME_BITS + 1);
   localparam logic [BC_W-1:0] FRAME_BITS_C = BC_W'(FRAME_BITS);

   // ---------------- configuration registers ----------------
   logic                       rx_act_ff;
   logic                       tx_act_ff;
   logic [mft_pkg::CNT_W-1:0]  mid_thr_ff;
   logic [mft_pkg::CNT_W-1:0]  rx_tmo_ff;
   logic [mft_pkg::CNT_W-1:0]  half_per_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_act_ff   <= mft_pkg::RST_RX_ACTIVE_LEVEL;
         tx_act_ff   <= mft_pkg::RST_TX_ACTIVE_LEVEL;
         mid_thr_ff  <= mft_pkg::RST_MID_BIT_THRESHOLD;
         rx_tmo_ff   <= mft_pkg::RST_RX_TIMEOUT;
         half_per_ff <= mft_pkg::RST_HALF_BIT_PERIOD;
      end else if (csr_we) begin
         unique case (csr_index)
            mft_pkg::CSR_RX_ACTIVE_LEVEL:   rx_act_ff   <= csr_wdata[0];
            mft_pkg::CSR_TX_ACTIVE_LEVEL:   tx_act_ff   <= csr_wdata[0];
            mft_pkg::CSR_MID_BIT_THRESHOLD: mid_thr_ff  <= csr_wdata;
            mft_pkg::CSR_RX_TIMEOUT:        rx_tmo_ff   <= csr_wdata;
            mft_pkg::CSR_HALF_BIT_PERIOD:   half_per_ff <= csr_wdata;
            default: ;  // writes beyond the register list are dropped
         endcase
      end
   end

   // ---------------- handshake ----------------
   logic        s1_valid_ff;
   logic        s1_action_ff;
   logic        s1_rx_ff;
   logic [31:0] s1_frame_ff;
   logic        rsp_valid_ff;

   logic advance;    // the stage 1 item moves into the result register
   logic accept;     // a new item enters stage 1

   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_action_ff <= req_action;
         s1_rx_ff     <= req_rx_level;
         s1_frame_ff  <= req_tx_frame;
      end
   end

   // ---------------- transceiver state ----------------
   mft_pkg::mode_type          mode_ff, mode_in;
   logic                       prev_rx_ff, prev_rx_in;
   logic [mft_pkg::CNT_W-1:0]  elapsed_ff, elapsed_in;
   logic [31:0]                rx_shift_ff, rx_shift_in;
   logic [BC_W-1:0]            bit_cnt_ff, bit_cnt_in;
   // transmit word aligned so that the next bit to send is always the MSB
   logic [FRAME_BITS-1:0]      tx_shift_ff, tx_shift_in;
   logic                       half_ff, half_in;
   logic [mft_pkg::CNT_W-1:0]  hbt_ff, hbt_in;
   logic                       tx_lvl_ff, tx_lvl_in;

   logic                       frm_valid;
   logic                       frm_error;
   logic [FRAME_BITS+31:0]     frame_ext;

   // zero extend, then keep the low FRAME_BITS bits (higher positions never go out)
   assign frame_ext = {{FRAME_BITS{1'b0}}, s1_frame_ff};

   always_comb begin
      logic edge_seen;
      logic to_idle;
      logic p;

      mode_in     = mode_ff;
      prev_rx_in  = prev_rx_ff;
      elapsed_in  = elapsed_ff;
      rx_shift_in = rx_shift_ff;
      bit_cnt_in  = bit_cnt_ff;
      tx_shift_in = tx_shift_ff;
      half_in     = half_ff;
      hbt_in      = hbt_ff;
      tx_lvl_in   = tx_lvl_ff;
      frm_valid   = 1'b0;
      frm_error   = 1'b0;

      edge_seen = (s1_rx_ff != prev_rx_ff);
      to_idle   = (s1_rx_ff != rx_act_ff);
      p         = half_ff;

      if (s1_action_ff) begin
         // send item: restart transmission, aborting anything in progress
         tx_shift_in = frame_ext[FRAME_BITS-1:0];
         mode_in     = mft_pkg::MODE_TX_START;
         half_in     = 1'b0;
         hbt_in      = '0;
         bit_cnt_in  = '0;
      end else if (mode_ff == mft_pkg::MODE_TX_START || mode_ff == mft_pkg::MODE_TX_FRAME ||
                   mode_ff == mft_pkg::MODE_TX_STOP  || mode_ff == mft_pkg::MODE_TX_IDLE) begin
         hbt_in = mft_pkg::sat_inc(hbt_ff);
         if (hbt_in >= half_per_ff) begin
            // half-bit boundary
            hbt_in = '0;
            unique case (mode_ff)
               mft_pkg::MODE_TX_START: begin
                  tx_lvl_in = ~p;
                  if (p) begin
                     mode_in    = mft_pkg::MODE_TX_FRAME;
                     bit_cnt_in = '0;
                  end
               end
               mft_pkg::MODE_TX_FRAME: begin
                  tx_lvl_in = p ^ tx_shift_ff[FRAME_BITS-1];
                  if (p) begin
                     bit_cnt_in  = bit_cnt_ff + 1'b1;
                     tx_shift_in = tx_shift_ff << 1;
                  end
                  if (bit_cnt_in >= FRAME_BITS_C) begin
                     mode_in = mft_pkg::MODE_TX_STOP;
                  end
               end
               mft_pkg::MODE_TX_STOP: begin
                  tx_lvl_in = ~p;
                  if (p) begin
                     mode_in = mft_pkg::MODE_TX_IDLE;
                  end
               end
               default: begin  // trailing idle half bit
                  tx_lvl_in = 1'b0;
                  mode_in   = mft_pkg::MODE_WAIT_START;
               end
            endcase
            half_in = ~p;
         end
         // receive edges ignored while sending, but the level is still tracked
         prev_rx_in = s1_rx_ff;
      end else begin
         elapsed_in = mft_pkg::sat_inc(elapsed_ff);
         if (edge_seen) begin
            unique case (mode_ff)
               mft_pkg::MODE_WAIT_START: begin
                  if (to_idle) begin
                     mode_in     = mft_pkg::MODE_RX_FRAME;
                     elapsed_in  = '0;
                     rx_shift_in = '0;
                     bit_cnt_in  = '0;
                  end
               end
               mft_pkg::MODE_RX_FRAME: begin
                  // edges near mid-bit are transition edges, not bits
                  if (elapsed_in > mid_thr_ff) begin
                     rx_shift_in = {rx_shift_ff[30:0], s1_rx_ff ^ rx_act_ff};
                     bit_cnt_in  = bit_cnt_ff + 1'b1;
                     elapsed_in  = '0;
                  end
                  if (bit_cnt_in >= FRAME_BITS_C) begin
                     mode_in = mft_pkg::MODE_WAIT_STOP;
                  end
               end
               mft_pkg::MODE_WAIT_STOP: begin
                  if (elapsed_in > mid_thr_ff && to_idle) begin
                     frm_valid = 1'b1;
                     mode_in   = mft_pkg::MODE_WAIT_START;
                  end
               end
               default: begin  // error: any edge resynchronizes
                  mode_in = mft_pkg::MODE_WAIT_START;
               end
            endcase
         end
         if ((mode_in == mft_pkg::MODE_RX_FRAME || mode_in == mft_pkg::MODE_WAIT_STOP) &&
             elapsed_in >= rx_tmo_ff) begin
            mode_in   = mft_pkg::MODE_RX_ERROR;
            frm_error = 1'b1;
         end
         prev_rx_in = s1_rx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= mft_pkg::MODE_WAIT_START;
         prev_rx_ff  <= mft_pkg::RST_RX_ACTIVE_LEVEL;
         elapsed_ff  <= '0;
         rx_shift_ff <= '0;
         bit_cnt_ff  <= '0;
         tx_shift_ff <= '0;
         half_ff     <= 1'b0;
         hbt_ff      <= '0;
         tx_lvl_ff   <= 1'b0;
      end else if (advance) begin
         mode_ff     <= mode_in;
         prev_rx_ff  <= prev_rx_in;
         elapsed_ff  <= elapsed_in;
         rx_shift_ff <= rx_shift_in;
         bit_cnt_ff  <= bit_cnt_in;
         tx_shift_ff <= tx_shift_in;
         half_ff     <= half_in;
         hbt_ff      <= hbt_in;
         tx_lvl_ff   <= tx_lvl_in;
      end
   end

   // ---------------- result register ----------------
   logic        tx_line_ff;
   logic        frame_valid_ff;
   logic [31:0] frame_data_ff;
   logic        frame_error_ff;
   logic        tx_busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tx_line_ff     <= ~(tx_lvl_in ^ tx_act_ff);
         frame_valid_ff <= frm_valid;
         frame_data_ff  <= frm_valid ? rx_shift_ff : 32'd0;
         frame_error_ff <= frm_error;
         tx_busy_ff     <= (mode_in == mft_pkg::MODE_TX_START) ||
                           (mode_in == mft_pkg::MODE_TX_FRAME) ||
                           (mode_in == mft_pkg::MODE_TX_STOP)  ||
                           (mode_in == mft_pkg::MODE_TX_IDLE);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tx_line     = tx_line_ff;
   assign rsp_frame_valid = frame_valid_ff;
   assign rsp_frame_data  = frame_data_ff;
   assign rsp_frame_error = frame_error_ff;
   assign rsp_tx_busy     = tx_busy_ff;

endmodule

`default_nettype wire

// ----- tb/mft_line_checker.sv -----
`timescale 1ns / 1ps

module mft_line_checker #(
   parameter int FRAME_BITS = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [mft_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mft_pkg::CNT_W-1:0]      csr_wdata,
   input  wire logic                           req_valid,
   input  wire logic                           req_stall,
   input  wire logic                           req_action,
   input  wire logic                           req_rx_level,
   input  wire logic [31:0]                    req_tx_frame,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   input  wire logic                           rsp_tx_line,
   input  wire logic                           rsp_frame_valid,
   input  wire logic [31:0]                    rsp_frame_data,
   input  wire logic                           rsp_frame_error,
   input  wire logic                           rsp_tx_busy,
   output int                                  fail_count,
   output int                                  pending,
   output int                                  frames_rx,
   output int                                  frame_errs,
   output int                                  checked
);

   typedef struct packed {
      logic        tx_line;
      logic        frame_valid;
      logic [31:0] frame_data;
      logic        frame_error;
      logic        tx_busy;
   } line_out_type;

   // register copy
   logic                      rx_act, tx_act;
   logic [mft_pkg::CNT_W-1:0] mid_thr, rx_tmo, half_per;

   // transceiver state
   mft_pkg::mode_type         mode;
   logic                      prev_rx, half_ph, tx_lvl;
   logic [mft_pkg::CNT_W-1:0] elapsed, half_ticks;
   logic [31:0]               rx_word, tx_word;
   logic [6:0]                bit_cnt;

   line_out_type     awaited_lines[$];

   function automatic logic tx_mode(input mft_pkg::mode_type m);
      return m == mft_pkg::MODE_TX_START || m == mft_pkg::MODE_TX_FRAME ||
             m == mft_pkg::MODE_TX_STOP  || m == mft_pkg::MODE_TX_IDLE;
   endfunction

   task clear_line_state();
      rx_act     = mft_pkg::RST_RX_ACTIVE_LEVEL;
      tx_act     = mft_pkg::RST_TX_ACTIVE_LEVEL;
      mid_thr    = mft_pkg::RST_MID_BIT_THRESHOLD;
      rx_tmo     = mft_pkg::RST_RX_TIMEOUT;
      half_per   = mft_pkg::RST_HALF_BIT_PERIOD;
      mode       = mft_pkg::MODE_WAIT_START;
      prev_rx    = mft_pkg::RST_RX_ACTIVE_LEVEL;
      elapsed    = '0;
      half_ticks = '0;
      rx_word    = '0;
      tx_word    = '0;
      bit_cnt    = '0;
      half_ph    = 1'b0;
      tx_lvl     = 1'b0;
   endtask

   // one half-bit boundary of the transmitter
   task step_tx_half();
      logic p;
      int   pos;
      p = half_ph;
      case (mode)
         mft_pkg::MODE_TX_START: begin
            tx_lvl = ~p;
            if (p) begin
               mode    = mft_pkg::MODE_TX_FRAME;
               bit_cnt = '0;
            end
         end
         mft_pkg::MODE_TX_FRAME: begin
            pos    = FRAME_BITS - 1 - int'(bit_cnt);
            tx_lvl = p ^ ((pos < 32) ? tx_word[pos] : 1'b0);
            if (p) bit_cnt = bit_cnt + 1'b1;
            if (bit_cnt >= FRAME_BITS) mode = mft_pkg::MODE_TX_STOP;
         end
         mft_pkg::MODE_TX_STOP: begin
            tx_lvl = ~p;
            if (p) mode = mft_pkg::MODE_TX_IDLE;
         end
         mft_pkg::MODE_TX_IDLE: begin
            tx_lvl = 1'b0;
            mode   = mft_pkg::MODE_WAIT_START;
         end
         default: ;
      endcase
      half_ph = ~p;
   endtask

   task predict_line(input logic act, input logic rx, input logic [31:0] word,
                     output line_out_type r);
      logic moved, leaving;
      r = '0;
      if (act) begin
         tx_word    = word;
         mode       = mft_pkg::MODE_TX_START;
         half_ph    = 1'b0;
         half_ticks = '0;
         bit_cnt    = '0;
      end else if (tx_mode(mode)) begin
         half_ticks = (half_ticks == mft_pkg::CNT_MAX) ? half_ticks : half_ticks + 1'b1;
         if (half_ticks >= half_per) begin
            half_ticks = '0;
            step_tx_half();
         end
         prev_rx = rx;
      end else begin
         moved   = (rx != prev_rx);
         leaving = (rx != rx_act);
         elapsed = (elapsed == mft_pkg::CNT_MAX) ? elapsed : elapsed + 1'b1;
         if (moved) begin
            case (mode)
               mft_pkg::MODE_WAIT_START: begin
                  if (leaving) begin
                     mode    = mft_pkg::MODE_RX_FRAME;
                     elapsed = '0;
                     rx_word = '0;
                     bit_cnt = '0;
                  end
               end
               mft_pkg::MODE_RX_FRAME: begin
                  if (elapsed > mid_thr) begin
                     rx_word = {rx_word[30:0], rx ^ rx_act};
                     bit_cnt = bit_cnt + 1'b1;
                     elapsed = '0;
                  end
                  if (bit_cnt >= FRAME_BITS) mode = mft_pkg::MODE_WAIT_STOP;
               end
               mft_pkg::MODE_WAIT_STOP: begin
                  if (elapsed > mid_thr && leaving) begin
                     r.frame_valid = 1'b1;
                     r.frame_data  = rx_word;
                     mode          = mft_pkg::MODE_WAIT_START;
                  end
               end
               default: mode = mft_pkg::MODE_WAIT_START;
            endcase
         end
         if ((mode == mft_pkg::MODE_RX_FRAME || mode == mft_pkg::MODE_WAIT_STOP) &&
             elapsed >= rx_tmo) begin
            mode          = mft_pkg::MODE_RX_ERROR;
            r.frame_error = 1'b1;
         end
         prev_rx = rx;
      end
      r.tx_line = ~(tx_lvl ^ tx_act);
      r.tx_busy = tx_mode(mode);
   endtask

   task note_mismatch(input string what, input logic [31:0] got_v, input logic [31:0] want_v);
      $display("line check: %s wrong on result %0d: got %0h, wanted %0h",
               what, checked, got_v, want_v);
      fail_count++;
   endtask

   always @(posedge clock) begin
      line_out_type want, got;
      if (reset) begin
         clear_line_state();
         awaited_lines.delete();
         fail_count = 0;
         frames_rx  = 0;
         frame_errs = 0;
         checked    = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               mft_pkg::CSR_RX_ACTIVE_LEVEL:   rx_act   = csr_wdata[0];
               mft_pkg::CSR_TX_ACTIVE_LEVEL:   tx_act   = csr_wdata[0];
               mft_pkg::CSR_MID_BIT_THRESHOLD: mid_thr  = csr_wdata;
               mft_pkg::CSR_RX_TIMEOUT:        rx_tmo   = csr_wdata;
               mft_pkg::CSR_HALF_BIT_PERIOD:   half_per = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            predict_line(req_action, req_rx_level, req_tx_frame, want);
            if (want.frame_valid) frames_rx++;
            if (want.frame_error) frame_errs++;
            awaited_lines.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_tx_line, rsp_frame_valid, rsp_frame_data, rsp_frame_error,
                   rsp_tx_busy};
            if (awaited_lines.size() == 0) begin
               note_mismatch("unexpected result", got.frame_data, '0);
            end else begin
               want = awaited_lines.pop_front();
               if (got.tx_line !== want.tx_line)
                  note_mismatch("tx_line", got.tx_line, want.tx_line);
               if (got.frame_valid !== want.frame_valid)
                  note_mismatch("frame_valid", got.frame_valid, want.frame_valid);
               if (got.frame_data !== want.frame_data)
                  note_mismatch("frame_data", got.frame_data, want.frame_data);
               if (got.frame_error !== want.frame_error)
                  note_mismatch("frame_error", got.frame_error, want.frame_error);
               if (got.tx_busy !== want.tx_busy)
                  note_mismatch("tx_busy", got.tx_busy, want.tx_busy);
            end
            checked++;
         end
      end
      pending <= awaited_lines.size();
   end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

   // clock and the single reset at the start
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // block inputs, all known from time zero
   logic                          csr_we       = 1'b0;
   logic [mft_pkg::CSR_IDX_W-1:0] csr_index    = mft_pkg::CSR_RX_ACTIVE_LEVEL;
   logic [mft_pkg::CNT_W-1:0]     csr_wdata    = '0;
   logic                          req_valid    = 1'b0;
   logic                          req_action   = 1'b0;
   logic                          req_rx_level = 1'b1;
   logic [31:0]                   req_tx_frame = '0;
   logic                          rsp_stall    = 1'b0;

   // block outputs
   logic        req_stall;
   logic        rsp_valid;
   logic        rsp_tx_line;
   logic        rsp_frame_valid;
   logic [31:0] rsp_frame_data;
   logic        rsp_frame_error;
   logic        rsp_tx_busy;

   // checker results
   int fail_count, pending, frames_rx, frame_errs, checked;

   // stimulus bookkeeping
   int   items_sent = 0;
   int   sends      = 0;
   int   settings   = 0;
   logic idle_en    = 1'b1;  // sender gaps allowed
   logic stall_en   = 1'b1;  // receiver stall bursts allowed
   logic hold_ask   = 1'b0;  // one long receiver hold-off, requested by the sender side
   logic hold_done  = 1'b0;

   // current register settings, mirrored for shaping the stimulus
   logic                      cur_rxa;
   logic [mft_pkg::CNT_W-1:0] cur_to, cur_half;
   int                        cur_lo, cur_hi;  // half-bit length range that the receiver accepts

   manchester_frame_transceiver_unit #(.FRAME_BITS(32)) dut (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_rx_level    (req_rx_level),
      .req_tx_frame    (req_tx_frame),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_tx_line     (rsp_tx_line),
      .rsp_frame_valid (rsp_frame_valid),
      .rsp_frame_data  (rsp_frame_data),
      .rsp_frame_error (rsp_frame_error),
      .rsp_tx_busy     (rsp_tx_busy)
   );

   mft_line_checker #(.FRAME_BITS(32)) line_chk (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_rx_level    (req_rx_level),
      .req_tx_frame    (req_tx_frame),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_tx_line     (rsp_tx_line),
      .rsp_frame_valid (rsp_frame_valid),
      .rsp_frame_data  (rsp_frame_data),
      .rsp_frame_error (rsp_frame_error),
      .rsp_tx_busy     (rsp_tx_busy),
      .fail_count      (fail_count),
      .pending         (pending),
      .frames_rx       (frames_rx),
      .frame_errs      (frame_errs),
      .checked         (checked)
   );

   // Offer one item and hold it until the block takes it. req_stall is read right
   // after the edge, so it is the value the block saw at that edge.
   task put_item(input logic act, input logic rx, input logic [31:0] word);
      if (idle_en && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_action   <= act;
      req_rx_level <= rx;
      req_tx_frame <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (act) sends++;
      // ask for the long hold-off once, while the sender keeps going
      if (items_sent == 300) hold_ask = 1'b1;
   endtask

   // n ticks at one receive level; the frame word is junk on ticks
   task hold_line(input logic level, input int n);
      repeat (n) put_item(1'b0, level, $urandom());
   endtask

   // Manchester receive waveform: idle at the active level, start edge, data MSB
   // first (level after the mid-bit edge carries the bit), then optionally the stop
   // half-bits. Without a stop the line freezes; the timeout fires if it is below 100.
   task rx_frame(input logic [31:0] word, input int nbits, input logic with_stop,
                 input int tlo, input int thi);
      int   i;
      logic d, last;
      hold_line(cur_rxa, $urandom_range(1, 3));
      hold_line(~cur_rxa, $urandom_range(tlo, thi));
      last = ~cur_rxa;
      for (i = 0; i < nbits; i++) begin
         d = word[31-i];
         hold_line(~(d ^ cur_rxa), $urandom_range(tlo, thi));
         hold_line(d ^ cur_rxa, $urandom_range(tlo, thi));
         last = d ^ cur_rxa;
      end
      if (with_stop) begin
         hold_line(cur_rxa, $urandom_range(tlo, thi));
         hold_line(~cur_rxa, $urandom_range(tlo, thi));
         hold_line(cur_rxa, 1);
      end else begin
         hold_line(last, (cur_to < 100) ? int'(cur_to) + 2 : 20);
      end
   endtask

   task write_reg(input logic [mft_pkg::CSR_IDX_W-1:0] idx,
                  input logic [mft_pkg::CNT_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task set_regs(input logic rxa, input logic txa, input logic [mft_pkg::CNT_W-1:0] mid,
                 input logic [mft_pkg::CNT_W-1:0] tmo,
                 input logic [mft_pkg::CNT_W-1:0] half);
      write_reg(mft_pkg::CSR_RX_ACTIVE_LEVEL, {{(mft_pkg::CNT_W-1){1'b0}}, rxa});
      write_reg(mft_pkg::CSR_TX_ACTIVE_LEVEL, {{(mft_pkg::CNT_W-1){1'b0}}, txa});
      write_reg(mft_pkg::CSR_MID_BIT_THRESHOLD, mid);
      write_reg(mft_pkg::CSR_RX_TIMEOUT, tmo);
      write_reg(mft_pkg::CSR_HALF_BIT_PERIOD, half);
      csr_we   <= 1'b0;
      cur_rxa  = rxa;
      cur_to   = tmo;
      cur_half = half;
      settings++;
   endtask

   // Drop valid and wait until every expected result is back, with margin for the
   // two-stage pipe. The first edge lets the checker's count catch up.
   task settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task one_episode();
      int          pick, n, full;
      logic [31:0] w;
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
         0:       w = '0;
         1:       w = '1;
         default: w = $urandom();
      endcase
      if (pick < 55) begin
         // well-formed frame, jitter kept inside the accepted window
         rx_frame(w, 32, 1'b1, cur_lo, cur_hi);
      end else if (pick < 65) begin
         // cut short somewhere, including right before the stop edge
         rx_frame(w, $urandom_range(0, 32), 1'b0, cur_lo, cur_hi);
      end else if (pick < 80) begin
         // transmit; sometimes cut off by the next episode's send or start edge
         put_item(1'b1, 1'($urandom_range(0, 1)), w);
         full = 69 * ((cur_half == 0) ? 1 : int'(cur_half)) + 2;
         if (cur_half > 8) n = $urandom_range(10, 40);
         else if ($urandom_range(0, 3) == 0) n = $urandom_range(1, full);
         else n = full;
         repeat (n) put_item(1'b0, 1'($urandom_range(0, 1)), $urandom());
      end else if (pick < 90) begin
         repeat ($urandom_range(3, 20)) put_item(1'b0, 1'($urandom_range(0, 1)), $urandom());
      end else begin
         // timing outside the window: early and late edges
         rx_frame(w, 32, 1'b1, 1, cur_hi + 2);
      end
   endtask

   task run_phase(input int budget, input logic rxa, input logic txa,
                  input logic [mft_pkg::CNT_W-1:0] mid, input logic [mft_pkg::CNT_W-1:0] tmo,
                  input logic [mft_pkg::CNT_W-1:0] half, input int lo, input int hi);
      int start;
      settle();
      set_regs(rxa, txa, mid, tmo, half);
      cur_lo = lo;
      cur_hi = hi;
      start  = items_sent;
      while (items_sent - start < budget) one_episode();
   endtask

   // receiver side: random stall bursts, and once a long hold-off so the
   // two-stage pipe fills and pushes back on the sender
   initial begin
      wait (reset == 1'b0);
      forever begin
         if (hold_ask && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (80) @(posedge clock);
            hold_done = 1'b1;
         end else if (stall_en && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: short timeout, fast transmitter
      set_regs(1'b1, 1'b1, 12'd1, 12'd2, 12'd1);
      hold_line(1'b1, 2);                        // idle at the active level
      hold_line(1'b0, 3);                        // start edge, then timeout
      hold_line(1'b1, 1);                        // edge after error: back to waiting
      hold_line(1'b0, 1);                        // new start edge
      put_item(1'b1, 1'b0, 32'hFFFF_FFFF);       // send aborts the reception
      hold_line(1'b0, 1);
      hold_line(1'b1, 1);                        // receive edges ignored while sending
      hold_line(1'b0, 1);
      hold_line(1'b1, 1);
      put_item(1'b1, 1'b1, 32'h0000_0000);       // send while busy restarts
      hold_line(1'b1, 3);
      put_item(1'b1, 1'b0, 32'h8000_0001);
      hold_line(1'b0, 3);

      // random: legal windows need mid >= longest half and < twice the shortest,
      // and the timeout above two of the longest halves
      run_phase(150, 1'b1, 1'b1, 12'd1, 12'd3, 12'd1, 1, 1);
      run_phase(160, 1'b0, 1'b0, 12'd3, 12'd8, 12'd2, 2, 3);
      run_phase(120, 1'b1, 1'b0, 12'd5, 12'd12, 12'd3, 3, 5);
      // all-zero timing: every edge is a bit, every frame tick times out
      run_phase(90, 1'b0, 1'b1, 12'd0, 12'd0, 12'd0, 1, 2);
      // top of range: nothing counts as a bit, transmitter barely moves
      run_phase(60, 1'b1, 1'b1, 12'd4095, 12'd4095, 12'd4095, 1, 3);
      // closing stretch with no gaps or stalls
      idle_en  = 1'b0;
      stall_en = 1'b0;
      run_phase(150, 1'b0, 1'b0, 12'd2, 12'd6, 12'd1, 2, 2);

      settle();
      $display("run covered %0d items (%0d sends) under %0d register settings",
               items_sent, sends, settings);
      $display("%0d results checked; receiver side saw %0d complete frames, %0d timeouts",
               checked, frames_rx, frame_errs);
      if (fail_count == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // run limit, far above the slowest legal run
   initial begin
      #3000000;
      $display("status: fail");
      $finish;
   end

endmodule

// ----- manchester_frame_transceiver_unit.f -----
rtl/mft_pkg.sv
rtl/manchester_frame_transceiver_unit.sv
tb/mft_line_checker.sv
tb/tb.sv
